### hw/rtl/utnorm_pkg.sv
// Package: byte constants, result record and character class helpers for the text normalizer
package utnorm_pkg;

  localparam int unsigned ByteW = 8;

  localparam logic [7:0] SpaceByte   = 8'h20;
  localparam logic [7:0] CaseOffset  = 8'h20;
  localparam logic [7:0] UpperFirst  = 8'h41;
  localparam logic [7:0] UpperLast   = 8'h5A;
  localparam logic [7:0] Mask3       = 8'hE0;
  localparam logic [7:0] Lead2       = 8'hC0;
  localparam logic [7:0] Mask4       = 8'hF0;
  localparam logic [7:0] Lead3       = 8'hE0;
  localparam logic [7:0] Mask5       = 8'hF8;
  localparam logic [7:0] Lead4       = 8'hF0;
  localparam logic [7:0] CyrLead     = 8'hD0;
  localparam logic [7:0] CyrFirst    = 8'h90;
  localparam logic [7:0] CyrLast     = 8'hAF;
  localparam logic [7:0] GrkLead     = 8'hCE;
  localparam logic [7:0] GrkFirst    = 8'h91;
  localparam logic [7:0] GrkLast     = 8'hAB;

  // One result as it leaves the block
  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic             byte_valid;
    logic             last;
  } utnorm_res_t;

  // Sequence length minus one, taken from the top bits of a lead byte
  function automatic logic [1:0] seq_extra(input logic [7:0] b);
    logic [1:0] r;
    r = 2'd0;
    if (b[7] == 1'b0) begin
      r = 2'd0;
    end else if ((b & Mask3) == Lead2) begin
      r = 2'd1;
    end else if ((b & Mask4) == Lead3) begin
      r = 2'd2;
    end else if ((b & Mask5) == Lead4) begin
      r = 2'd3;
    end
    return r;
  endfunction

  // ASCII whitespace or punctuation
  function automatic logic is_sep(input logic [7:0] b);
    return (b >= 8'h09 && b <= 8'h0D) || (b >= 8'h20 && b <= 8'h2F) ||
           (b >= 8'h3A && b <= 8'h40) || (b >= 8'h5B && b <= 8'h60) ||
           (b >= 8'h7B && b <= 8'h7E);
  endfunction

endpackage

### hw/rtl/utnorm_if.sv
// Interfaces: text byte channel and normalized result channel
interface utnorm_in_if import utnorm_pkg::*;;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] text_byte;
  logic             end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface utnorm_out_if import utnorm_pkg::*;;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] out_byte;
  logic             byte_valid;
  logic             last;

  modport source (output valid, output out_byte, output byte_valid, output last, input ready);
  modport sink   (input valid, input out_byte, input byte_valid, input last, output ready);
endinterface

### hw/rtl/utf8_text_normalizer.sv
// UTF-8 text normalizer: lowercasing, separator collapsing and two-byte letter folding
//
// text_i carries one UTF-8 byte per request with end_of_text on the final byte
// of a text. norm_o returns the normalized bytes: up to two results for one
// request (a held space followed by the kept byte), or one end marker with
// byte_valid low when the final request produces nothing. The final result of
// a text has last high, and all normalizer state then returns to reset.
// An accepted request is registered, and its results then enter the result queue.
// Throughput: one request per cycle. A request is processed only when the
// four-entry result queue has room for two results, so the output port, which
// drains one result per cycle, sets the sustained rate: texts whose requests
// mostly give one result run at one byte per cycle.
// When the receiver stalls, results wait in the queue and text_i.ready drops
// once the input register holds a request the queue cannot take.
// Reset empties the input register and the queue and clears the space,
// started, lead and continuation state.
module utf8_text_normalizer import utnorm_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  utnorm_in_if.sink           text_i,
  utnorm_out_if.source        norm_o
);

  localparam int unsigned QDepth = 4;

  // Input register
  logic             in_vld_q, in_vld_d;
  logic [ByteW-1:0] in_byte_q;
  logic             in_end_q;

  // Normalizer state
  logic             space_q, space_d;
  logic             started_q, started_d;
  logic [ByteW-1:0] held_q, held_d;
  logic             fold_q, fold_d;
  logic [1:0]       raw_q, raw_d;

  // Result queue
  utnorm_res_t fifo_q [QDepth];
  logic [1:0]  wr_ptr_q, rd_ptr_q;
  logic [2:0]  cnt_q;

  logic        proc;
  logic        in_acc;
  logic        pop;
  logic [1:0]  n_res;
  utnorm_res_t res0, res1;

  assign proc   = in_vld_q && (cnt_q <= 3'd2);
  assign in_acc = text_i.valid && text_i.ready;
  assign pop    = norm_o.valid && norm_o.ready;

  assign text_i.ready = !in_vld_q || proc;

  // Hold a request in the input register until the queue can take it
  always_comb begin
    in_vld_d = in_vld_q;
    if (in_acc) begin
      in_vld_d = 1'b1;
    end else if (proc) begin
      in_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_byte_q <= text_i.text_byte;
      in_end_q  <= text_i.end_of_text;
    end
  end

  // Normalize the registered byte into up to two results
  always_comb begin
    logic [1:0]       extra;
    logic [ByteW-1:0] b;
    logic [ByteW-1:0] o;
    b         = in_byte_q;
    extra     = seq_extra(b);
    o         = b;
    space_d   = space_q;
    started_d = started_q;
    held_d    = held_q;
    fold_d    = fold_q;
    raw_d     = raw_q;
    n_res     = 2'd0;
    res0      = '{out_byte: b, byte_valid: 1'b1, last: 1'b0};
    res1      = '{out_byte: b, byte_valid: 1'b1, last: 1'b0};

    if (fold_q) begin
      // Second byte of a pair: fold capital Cyrillic and Greek letters
      if ((held_q == CyrLead && b >= CyrFirst && b <= CyrLast) ||
          (held_q == GrkLead && b >= GrkFirst && b <= GrkLast)) begin
        o = b + CaseOffset;
      end
      res0.out_byte = o;
      n_res         = 2'd1;
      fold_d        = 1'b0;
      held_d        = '0;
    end else if (raw_q != 2'd0) begin
      // Copy a continuation byte of a long sequence
      n_res = 2'd1;
      raw_d = raw_q - 2'd1;
    end else if (extra == 2'd0 && is_sep(b)) begin
      // Collapse separators into one held space
      if (started_q) begin
        space_d = 1'b1;
      end
    end else begin
      if (b >= UpperFirst && b <= UpperLast) begin
        o = b + CaseOffset;
      end
      if (space_q) begin
        res0.out_byte = SpaceByte;
        res1.out_byte = o;
        n_res         = 2'd2;
        space_d       = 1'b0;
      end else begin
        res0.out_byte = o;
        n_res         = 2'd1;
      end
      started_d = 1'b1;
      if (extra == 2'd1) begin
        fold_d = 1'b1;
        held_d = b;
      end else if (extra != 2'd0) begin
        raw_d = extra;
      end
    end

    // Close the text: mark the final result and drop all state
    if (in_end_q) begin
      case (n_res)
        2'd0: begin
          res0  = '{out_byte: '0, byte_valid: 1'b0, last: 1'b1};
          n_res = 2'd1;
        end
        2'd1:    res0.last = 1'b1;
        default: res1.last = 1'b1;
      endcase
      space_d   = 1'b0;
      started_d = 1'b0;
      held_d    = '0;
      fold_d    = 1'b0;
      raw_d     = 2'd0;
    end
  end

  // Advance normalizer state on each processed byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      space_q   <= 1'b0;
      started_q <= 1'b0;
      held_q    <= '0;
      fold_q    <= 1'b0;
      raw_q     <= 2'd0;
    end else if (proc) begin
      space_q   <= space_d;
      started_q <= started_d;
      held_q    <= held_d;
      fold_q    <= fold_d;
      raw_q     <= raw_d;
    end
  end

  // Push results into the queue
  always_ff @(posedge clk_i) begin
    if (proc && n_res != 2'd0) begin
      fifo_q[wr_ptr_q] <= res0;
    end
    if (proc && n_res == 2'd2) begin
      fifo_q[wr_ptr_q + 2'd1] <= res1;
    end
  end

  // Track queue pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 2'd0;
      rd_ptr_q <= 2'd0;
      cnt_q    <= 3'd0;
    end else begin
      if (proc) begin
        wr_ptr_q <= wr_ptr_q + n_res;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 2'd1;
      end
      cnt_q <= cnt_q + (proc ? {1'b0, n_res} : 3'd0) - {2'b0, pop};
    end
  end

  // Drive the queue head
  assign norm_o.valid      = (cnt_q != 3'd0);
  assign norm_o.out_byte   = fifo_q[rd_ptr_q].out_byte;
  assign norm_o.byte_valid = fifo_q[rd_ptr_q].byte_valid;
  assign norm_o.last       = fifo_q[rd_ptr_q].last;

endmodule

### hw/rtl/utnorm_checker.sv
// Checker: port-level properties of the text normalizer, bound to the top level
module utnorm_checker import utnorm_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [ByteW-1:0] out_byte_i,
  input logic             byte_valid_i,
  input logic             last_i
);

  // A stalled result holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(out_byte_i) && $stable(byte_valid_i) && $stable(last_i))
    else $error("stalled result changed");

  // An end marker is always the final result and carries a zero byte
  a_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !byte_valid_i |-> last_i && (out_byte_i == '0))
    else $error("malformed end marker");

  // Backpressure on the input only comes from pending results
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i)
    else $error("input stalled with no result pending");

endmodule

bind utf8_text_normalizer utnorm_checker u_utnorm_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready_i   (text_i.ready),
  .out_valid_i  (norm_o.valid),
  .out_ready_i  (norm_o.ready),
  .out_byte_i   (norm_o.out_byte),
  .byte_valid_i (norm_o.byte_valid),
  .last_i       (norm_o.last)
);

### sim/tb_utf8_text_normalizer.sv
// Testbench for the UTF-8 text normalizer: directed table, random texts, scoreboard
module tb_utf8_text_normalizer;
  import utnorm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEMS    = 1350;
  localparam int HOLD_CYC = 300;
  localparam int DRAIN    = 12;
  localparam int WATCHDOG = 3000;
  localparam int PRED     = -1;
  localparam utnorm_res_t NONE = '0;

  // One directed request; n < 0 means the predictor supplies the results
  typedef struct {
    logic [7:0]  b;
    logic        eot;
    int          n;
    utnorm_res_t r0;
    utnorm_res_t r1;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  utnorm_in_if  text_if ();
  utnorm_out_if norm_if ();

  utf8_text_normalizer DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .text_i (text_if),
    .norm_o (norm_if)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Normalizer state mirrored by the predictor
  logic       sp_held;
  logic       started;
  logic [7:0] lead_q;
  logic       pair_open;
  logic [1:0] cont_left;

  utnorm_res_t norm_q [$];
  int          pin_n;
  utnorm_res_t pin_r0, pin_r1;
  int          fed_cnt, text_cnt, res_cnt, mism, idle_cnt;
  logic        hold_req, hold_active, quiet, calm;

  dir_row_t dir_tab [28] = '{
    '{8'h41, 1'b0, 1, {8'h61, 1'b1, 1'b0}, NONE},
    '{8'h20, 1'b0, 0, NONE, NONE},
    '{8'h5A, 1'b0, 2, {SpaceByte, 1'b1, 1'b0}, {8'h7A, 1'b1, 1'b0}},
    '{8'h09, 1'b0, PRED, NONE, NONE},
    '{8'h2F, 1'b0, PRED, NONE, NONE},
    '{8'h5B, 1'b0, PRED, NONE, NONE},
    '{8'h7E, 1'b0, PRED, NONE, NONE},
    '{8'h39, 1'b0, PRED, NONE, NONE},
    '{8'hD0, 1'b0, PRED, NONE, NONE},
    '{8'hAF, 1'b0, PRED, NONE, NONE},
    '{8'hCE, 1'b0, PRED, NONE, NONE},
    '{8'h91, 1'b0, PRED, NONE, NONE},
    '{8'hC3, 1'b0, PRED, NONE, NONE},
    '{8'h2C, 1'b0, PRED, NONE, NONE},
    '{8'hE2, 1'b0, PRED, NONE, NONE},
    '{8'h80, 1'b0, PRED, NONE, NONE},
    '{8'h94, 1'b0, PRED, NONE, NONE},
    '{8'hF0, 1'b0, PRED, NONE, NONE},
    '{8'h9F, 1'b0, PRED, NONE, NONE},
    '{8'h98, 1'b0, PRED, NONE, NONE},
    '{8'h80, 1'b0, PRED, NONE, NONE},
    '{8'hFF, 1'b0, PRED, NONE, NONE},
    '{8'h0D, 1'b1, 1, {8'h00, 1'b0, 1'b1}, NONE},
    '{8'h0A, 1'b1, 1, {8'h00, 1'b0, 1'b1}, NONE},
    '{8'h01, 1'b1, 1, {8'h01, 1'b1, 1'b1}, NONE},
    '{8'hE2, 1'b1, 1, {8'hE2, 1'b1, 1'b1}, NONE},
    '{8'hD0, 1'b0, PRED, NONE, NONE},
    '{8'h5A, 1'b1, PRED, NONE, NONE}
  };

  // Compute the results of one text byte and advance the mirrored state
  function automatic void normalize_byte(input logic [7:0] b, input logic eot,
                                         output int n, output utnorm_res_t r0,
                                         output utnorm_res_t r1);
    utnorm_res_t r [2];
    int          len;
    logic [7:0]  o;
    n = 0;
    r[0] = '0;
    r[1] = '0;
    o = b;
    if (pair_open) begin
      if ((lead_q == CyrLead && b >= CyrFirst && b <= CyrLast) ||
          (lead_q == GrkLead && b >= GrkFirst && b <= GrkLast)) begin
        o = b + CaseOffset;
      end
      r[n] = {o, 1'b1, 1'b0};
      n++;
      pair_open = 1'b0;
      lead_q = 8'h00;
    end else if (cont_left != 2'd0) begin
      r[n] = {b, 1'b1, 1'b0};
      n++;
      cont_left = cont_left - 2'd1;
    end else begin
      casez (b)
        8'b0???????: len = 1;
        8'b110?????: len = 2;
        8'b1110????: len = 3;
        8'b11110???: len = 4;
        default:     len = 1;
      endcase
      if (len == 1 && b inside {[8'h09:8'h0D], [8'h20:8'h2F], [8'h3A:8'h40],
                                [8'h5B:8'h60], [8'h7B:8'h7E]}) begin
        if (started) sp_held = 1'b1;
      end else begin
        if (sp_held) begin
          r[n] = {SpaceByte, 1'b1, 1'b0};
          n++;
          sp_held = 1'b0;
        end
        if (b >= UpperFirst && b <= UpperLast) o = b + CaseOffset;
        r[n] = {o, 1'b1, 1'b0};
        n++;
        started = 1'b1;
        if (len == 2) begin
          pair_open = 1'b1;
          lead_q = b;
        end else if (len >= 3) begin
          cont_left = 2'(len - 1);
        end
      end
    end
    if (eot) begin
      if (n == 0) begin
        r[0] = {8'h00, 1'b0, 1'b0};
        n = 1;
      end
      r[n-1].last = 1'b1;
      sp_held = 1'b0;
      started = 1'b0;
      lead_q = 8'h00;
      pair_open = 1'b0;
      cont_left = 2'd0;
    end
    r0 = r[0];
    r1 = r[1];
  endfunction

  // Pick a random ASCII whitespace or punctuation byte
  function automatic logic [7:0] sep_byte();
    case ($urandom_range(0, 4))
      0:       return 8'($urandom_range(8'h09, 8'h0D));
      1:       return 8'($urandom_range(8'h20, 8'h2F));
      2:       return 8'($urandom_range(8'h3A, 8'h40));
      3:       return 8'($urandom_range(8'h5B, 8'h60));
      default: return 8'($urandom_range(8'h7B, 8'h7E));
    endcase
  endfunction

  // Offer one request at the falling edge and hold it until accepted
  task automatic put_byte(input logic [7:0] b, input logic eot, input int tn,
                          input utnorm_res_t t0, input utnorm_res_t t1);
    @(negedge clk_i);
    if (!calm && !quiet && !hold_active && $urandom_range(0, 7) == 0) begin
      text_if.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk_i);
    end
    text_if.valid       <= 1'b1;
    text_if.text_byte   <= b;
    text_if.end_of_text <= eot;
    pin_n  = tn;
    pin_r0 = t0;
    pin_r1 = t1;
    @(posedge clk_i);
    while (!text_if.ready) @(posedge clk_i);
    fed_cnt++;
  endtask

  // Predict accepted requests and check accepted results
  always @(posedge clk_i) begin : scoreboard
    int          pn;
    utnorm_res_t p0, p1, want;
    if (rst_ni && text_if.valid && text_if.ready) begin
      normalize_byte(text_if.text_byte, text_if.end_of_text, pn, p0, p1);
      if (pin_n >= 0) begin
        pn = pin_n;
        p0 = pin_r0;
        p1 = pin_r1;
      end
      if (pn > 0) norm_q.push_back(p0);
      if (pn > 1) norm_q.push_back(p1);
      if (text_if.end_of_text) text_cnt++;
    end
    if (rst_ni && norm_if.valid && norm_if.ready) begin
      res_cnt++;
      if (norm_q.size() == 0) begin
        $error("unexpected result: out_byte %h byte_valid %b last %b",
               norm_if.out_byte, norm_if.byte_valid, norm_if.last);
        mism++;
      end else begin
        want = norm_q.pop_front();
        if (norm_if.out_byte !== want.out_byte) begin
          $error("out_byte expected %h actual %h", want.out_byte, norm_if.out_byte);
          mism++;
        end
        if (norm_if.byte_valid !== want.byte_valid) begin
          $error("byte_valid expected %b actual %b", want.byte_valid, norm_if.byte_valid);
          mism++;
        end
        if (norm_if.last !== want.last) begin
          $error("last expected %b actual %b", want.last, norm_if.last);
          mism++;
        end
      end
    end
  end

  // End the run when nothing moves on either channel for too long
  always @(posedge clk_i) begin
    if ((text_if.valid && text_if.ready) || (norm_if.valid && norm_if.ready)) begin
      idle_cnt <= 0;
    end else if (idle_cnt >= WATCHDOG) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

  // Receiver: random stall bursts, one long hold-off, none at the end
  initial begin : receiver
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_active = 1'b1;
        norm_if.ready <= 1'b0;
        repeat (HOLD_CYC) @(negedge clk_i);
        hold_active = 1'b0;
        norm_if.ready <= 1'b1;
      end else if (!calm && !quiet && $urandom_range(0, 6) == 0) begin
        norm_if.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(negedge clk_i);
        norm_if.ready <= 1'b1;
      end else begin
        norm_if.ready <= 1'b1;
      end
    end
  end

  // Stimulus: reset, directed table, then random texts
  initial begin : stimulus
    logic [7:0] txt [$];
    int         chars, pick, k;
    text_if.valid       = 1'b0;
    text_if.text_byte   = 8'h01;
    text_if.end_of_text = 1'b0;
    norm_if.ready       = 1'b0;
    rst_ni      = 1'b0;
    pin_n       = PRED;
    pin_r0      = NONE;
    pin_r1      = NONE;
    hold_req    = 1'b0;
    hold_active = 1'b0;
    quiet       = 1'b0;
    calm        = 1'b0;
    fed_cnt     = 0;
    text_cnt    = 0;
    res_cnt     = 0;
    mism        = 0;
    idle_cnt    = 0;
    sp_held     = 1'b0;
    started     = 1'b0;
    lead_q      = 8'h00;
    pair_open   = 1'b0;
    cont_left   = 2'd0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_tab[i]) begin
      put_byte(dir_tab[i].b, dir_tab[i].eot, dir_tab[i].n, dir_tab[i].r0, dir_tab[i].r1);
    end

    // Stall the receiver for a long stretch while texts keep coming
    hold_req = 1'b1;

    while (fed_cnt < ITEMS) begin
      txt.delete();
      chars = ($urandom_range(0, 5) == 0) ? 1 : $urandom_range(2, 30);
      for (k = 0; k < chars; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 25) begin
          txt.push_back(8'($urandom_range(0, 1) ? $urandom_range(8'h41, 8'h5A)
                                                : $urandom_range(8'h61, 8'h7A)));
        end else if (pick < 35) begin
          txt.push_back(8'($urandom_range(8'h01, 8'h7F)));
        end else if (pick < 50) begin
          repeat ($urandom_range(1, 3)) txt.push_back(sep_byte());
        end else if (pick < 68) begin
          txt.push_back(pick < 60 ? CyrLead : GrkLead);
          txt.push_back(8'($urandom_range(8'h80, 8'hBF)));
        end else if (pick < 75) begin
          txt.push_back(8'($urandom_range(8'hC0, 8'hDF)));
          txt.push_back(8'($urandom_range(8'h80, 8'hBF)));
        end else if (pick < 82) begin
          txt.push_back(8'($urandom_range(8'hE0, 8'hEF)));
          repeat (2) txt.push_back(8'($urandom_range(8'h80, 8'hBF)));
        end else if (pick < 87) begin
          txt.push_back(8'($urandom_range(8'hF0, 8'hF7)));
          repeat (3) txt.push_back(8'($urandom_range(8'h80, 8'hBF)));
        end else if (pick < 94) begin
          txt.push_back(8'($urandom_range(8'h01, 8'hFF)));
        end else begin
          // Broken sequence: a lead followed by whatever comes
          txt.push_back(8'($urandom_range(8'hC0, 8'hF7)));
          if ($urandom_range(0, 1)) txt.push_back(sep_byte());
        end
      end
      // Cut the text inside a sequence now and then
      if ($urandom_range(0, 5) == 0) txt.push_back(8'($urandom_range(8'hC0, 8'hF7)));
      quiet = ($urandom_range(0, 3) == 0);
      calm  = (fed_cnt >= ITEMS * 85 / 100);
      foreach (txt[j]) put_byte(txt[j], j == txt.size() - 1, PRED, NONE, NONE);
    end

    @(negedge clk_i);
    text_if.valid <= 1'b0;
    while (norm_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);

    $display("Normalized %0d texts: %0d bytes in, %0d results checked, %0d mismatches",
             text_cnt, fed_cnt, res_cnt, mism);
    $display("Covered fold ranges, separators, raw multibyte, cut sequences, %0d-cycle stall",
             HOLD_CYC);
    if (mism == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
